>>> hw/rtl/lrmp_pkg.sv
// ----------------------------------------------------------------------------
// lrmp_pkg
// Shared types, constants and helpers for the linear recurrence term unit.
// ----------------------------------------------------------------------------
package lrmp_pkg;

    localparam int MAX_ORDER  = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_ORDER);
    localparam int ORDER_W    = 5;
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int TERM_W     = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int MAT_CELLS  = MAX_ORDER * MAX_ORDER;
    localparam int MEM_DEPTH  = 3 * MAT_CELLS;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_TERM  = 2'd0,
        KIND_COEF  = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER   = 1'b0,
        REG_MODULUS = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        SEL_BASE    = 2'd0,
        SEL_ACCUM   = 2'd1,
        SEL_SCRATCH = 2'd2
    } t_msel;

    typedef enum logic [1:0] {
        SA_MEM  = 2'd0,
        SA_COEF = 2'd1,
        SA_INIT = 2'd2
    } t_src_a;

    typedef enum logic {
        SB_MEM = 1'b0,
        SB_ONE = 1'b1
    } t_src_b;

    typedef enum logic [1:0] {
        WR_ZERO = 2'd0,
        WR_ONE  = 2'd1,
        WR_ACC  = 2'd2,
        WR_RD_A = 2'd3
    } t_wr_src;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [SLOT_W-1:0]     slot;
        logic [VALUE_BITS-1:0] value;
        logic [TERM_W-1:0]     term_number;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] term_value;
        logic                  error;
    } t_out_item;

    typedef struct packed {
        logic              load_init;
        logic              load_coef;
        logic              acc_clr;
        logic              mac_start;
        t_src_a            src_a;
        t_src_b            src_b;
        logic [IDX_W-1:0]  reg_idx;
        logic [MEM_AW-1:0] rd_a_addr;
        logic [MEM_AW-1:0] rd_b_addr;
        logic              wr_en;
        t_wr_src           wr_src;
        logic [MEM_AW-1:0] wr_addr;
    } t_cmd;

    typedef struct packed {
        logic mac_done;
    } t_sts;

    function automatic logic [MEM_AW-1:0] mat_addr(t_msel s, logic [IDX_W-1:0] i,
                                                   logic [IDX_W-1:0] j);
        int a;
        a = int'(s) * MAT_CELLS + int'(i) * MAX_ORDER + int'(j);
        return a[MEM_AW-1:0];
    endfunction

endpackage

>>> hw/rtl/lrmp_mulmod.sv
// ----------------------------------------------------------------------------
// lrmp_mulmod
// Bit-serial modular multiplier: a * b mod p, one bit of a per cycle.
// ----------------------------------------------------------------------------
module lrmp_mulmod (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lrmp_pkg::VALUE_BITS-1:0] i_a,
    input  logic [lrmp_pkg::VALUE_BITS-1:0] i_b,
    input  logic [lrmp_pkg::VALUE_BITS-1:0] i_p,
    output logic                           o_done,
    output logic [lrmp_pkg::VALUE_BITS-1:0] o_res
);
    import lrmp_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [VALUE_BITS-1:0] r_a, n_a;
    logic [VALUE_BITS-1:0] r_b, n_b;
    logic [VALUE_BITS-1:0] r_r, n_r;
    logic [VALUE_BITS:0]   dbl, dbl_red, sum;
    logic [VALUE_BITS:0]   p_ext;

    always_comb begin
        p_ext   = {1'b0, i_p};
        dbl     = {r_r, 1'b0};
        dbl_red = (dbl >= p_ext) ? dbl - p_ext : dbl;
        sum     = dbl_red + (r_a[VALUE_BITS-1] ? {1'b0, r_b} : '0);
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_r    = r_r;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(VALUE_BITS);
            n_a    = i_a;
            n_b    = i_b;
            n_r    = '0;
        end else if (r_busy) begin
            n_r   = (sum >= p_ext) ? VALUE_BITS'(sum - p_ext) : VALUE_BITS'(sum);
            n_a   = {r_a[VALUE_BITS-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_r <= n_r;
    end

    assign o_done = r_done;
    assign o_res  = r_r;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("multiply started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("start did not raise busy");

endmodule

>>> hw/rtl/lrmp_datapath.sv
// ----------------------------------------------------------------------------
// lrmp_datapath
// Loaded terms and coefficients, matrix memory, multiplier and accumulator.
// ----------------------------------------------------------------------------
module lrmp_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lrmp_pkg::t_cmd                  i_cmd,
    input  lrmp_pkg::t_in_item              i_in,
    input  logic [lrmp_pkg::VALUE_BITS-1:0] i_modulus,
    output lrmp_pkg::t_sts                  o_sts,
    output logic [lrmp_pkg::VALUE_BITS-1:0] o_acc
);
    import lrmp_pkg::*;

    logic [VALUE_BITS-1:0] r_init [MAX_ORDER];
    logic [VALUE_BITS-1:0] r_coef [MAX_ORDER];
    logic [VALUE_BITS-1:0] r_mem  [MEM_DEPTH];
    logic [VALUE_BITS-1:0] r_rd_a, r_rd_b;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [VALUE_BITS-1:0] p, one, op_a, op_b, wr_data, mul_res;
    logic [VALUE_BITS:0]   acc_sum;
    logic                  mul_done;

    assign p   = (i_modulus == '0) ? VALUE_BITS'(1) : i_modulus;
    assign one = (p == VALUE_BITS'(1)) ? '0 : VALUE_BITS'(1);

    always_comb begin
        case (i_cmd.src_a)
            SA_COEF: op_a = r_coef[i_cmd.reg_idx];
            SA_INIT: op_a = r_init[i_cmd.reg_idx];
            default: op_a = r_rd_a;
        endcase
        op_b = (i_cmd.src_b == SB_ONE) ? one : r_rd_b;
        case (i_cmd.wr_src)
            WR_ONE:  wr_data = one;
            WR_ACC:  wr_data = r_acc;
            WR_RD_A: wr_data = r_rd_a;
            default: wr_data = '0;
        endcase
    end

    lrmp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mac_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_p     (p),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    always_comb begin
        acc_sum = {1'b0, r_acc} + {1'b0, mul_res};
        n_acc   = r_acc;
        if (i_cmd.acc_clr) begin
            n_acc = '0;
        end else if (mul_done) begin
            n_acc = (acc_sum >= {1'b0, p}) ? VALUE_BITS'(acc_sum - {1'b0, p})
                                           : VALUE_BITS'(acc_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_cmd.load_init && int'(i_in.slot) < MAX_ORDER) begin
            r_init[i_in.slot[IDX_W-1:0]] <= i_in.value;
        end
        if (i_cmd.load_coef && int'(i_in.slot) < MAX_ORDER) begin
            r_coef[i_in.slot[IDX_W-1:0]] <= i_in.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[i_cmd.rd_a_addr];
        r_rd_b <= r_mem[i_cmd.rd_b_addr];
    end

    assign o_sts.mac_done = mul_done;
    assign o_acc          = r_acc;

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (int'(i_cmd.wr_addr) < MEM_DEPTH))
        else $error("matrix write out of range");

endmodule

>>> hw/rtl/lrmp_ctrl.sv
// ----------------------------------------------------------------------------
// lrmp_ctrl
// Sequencer: request decode, matrix build, square-and-multiply, final dot.
// ----------------------------------------------------------------------------
module lrmp_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  lrmp_pkg::t_in_item           i_in,
    input  logic [lrmp_pkg::ORDER_W-1:0] i_order,
    input  logic                         i_out_stall,
    input  lrmp_pkg::t_sts               i_sts,
    output lrmp_pkg::t_cmd               o_cmd,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output logic                         o_err
);
    import lrmp_pkg::*;

    typedef enum logic [17:0] {
        ST_IDLE    = 18'h00001,
        ST_SHORT   = 18'h00002,
        ST_BLD_ACC = 18'h00004,
        ST_BLD_BAS = 18'h00008,
        ST_BLD_MAC = 18'h00010,
        ST_BLD_WR  = 18'h00020,
        ST_EVAL    = 18'h00040,
        ST_SHIFT   = 18'h00080,
        ST_PRD_RD  = 18'h00100,
        ST_PRD_LAT = 18'h00200,
        ST_PRD_MAC = 18'h00400,
        ST_PRD_WR  = 18'h00800,
        ST_CPY_RD  = 18'h01000,
        ST_CPY_WR  = 18'h02000,
        ST_FIN_RD  = 18'h04000,
        ST_FIN_LAT = 18'h08000,
        ST_FIN_MAC = 18'h10000,
        ST_RESP    = 18'h20000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_i, n_i, r_j, n_j, r_t, n_t;
    logic [TERM_W-1:0] r_e, n_e;
    logic              r_sq, n_sq;
    logic              r_err, n_err;
    logic [IDX_W-1:0]  kmax, adv_i, adv_j;
    logic [TERM_W-1:0] k_ext;
    logic              cell_last, accept;
    t_msel             tgt;

    always_comb begin
        if (i_order == '0) begin
            kmax = '0;
        end else if (int'(i_order) > MAX_ORDER) begin
            kmax = IDX_W'(MAX_ORDER - 1);
        end else begin
            kmax = IDX_W'(i_order - ORDER_W'(1));
        end
        k_ext     = TERM_W'(kmax) + TERM_W'(1);
        cell_last = (r_i == kmax) && (r_j == kmax);
        adv_j     = (r_j == kmax) ? '0 : r_j + IDX_W'(1);
        adv_i     = cell_last ? '0 : ((r_j == kmax) ? r_i + IDX_W'(1) : r_i);
        tgt       = r_sq ? SEL_BASE : SEL_ACCUM;
        accept    = i_in_valid && (r_state == ST_IDLE);
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_t     = r_t;
        n_e     = r_e;
        n_sq    = r_sq;
        n_err   = r_err;
        o_cmd   = '0;
        o_cmd.src_a  = SA_MEM;
        o_cmd.src_b  = SB_MEM;
        o_cmd.wr_src = WR_ZERO;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in.kind)
                        KIND_TERM: o_cmd.load_init = 1'b1;
                        KIND_COEF: o_cmd.load_coef = 1'b1;
                        KIND_QUERY: begin
                            o_cmd.acc_clr = 1'b1;
                            if (i_in.term_number == '0) begin
                                n_err   = 1'b1;
                                n_state = ST_RESP;
                            end else if (i_in.term_number <= k_ext) begin
                                n_err           = 1'b0;
                                o_cmd.mac_start = 1'b1;
                                o_cmd.src_a     = SA_INIT;
                                o_cmd.src_b     = SB_ONE;
                                o_cmd.reg_idx   = kmax + IDX_W'(1)
                                                  - i_in.term_number[IDX_W-1:0];
                                n_state         = ST_SHORT;
                            end else begin
                                n_err   = 1'b0;
                                n_e     = i_in.term_number - k_ext;
                                n_i     = '0;
                                n_j     = '0;
                                n_state = ST_BLD_ACC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SHORT: begin
                if (i_sts.mac_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_BLD_ACC: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = mat_addr(SEL_ACCUM, r_i, r_j);
                o_cmd.wr_src  = (r_i == r_j) ? WR_ONE : WR_ZERO;
                n_i = adv_i;
                n_j = adv_j;
                if (cell_last) begin
                    n_state = ST_BLD_BAS;
                end
            end
            ST_BLD_BAS: begin
                if (r_i == '0) begin
                    o_cmd.acc_clr   = 1'b1;
                    o_cmd.mac_start = 1'b1;
                    o_cmd.src_a     = SA_COEF;
                    o_cmd.src_b     = SB_ONE;
                    o_cmd.reg_idx   = r_j;
                    n_state         = ST_BLD_MAC;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = mat_addr(SEL_BASE, r_i, r_j);
                    o_cmd.wr_src  = (r_i == r_j + IDX_W'(1)) ? WR_ONE : WR_ZERO;
                    n_i = adv_i;
                    n_j = adv_j;
                    if (cell_last) begin
                        n_state = ST_EVAL;
                    end
                end
            end
            ST_BLD_MAC: begin
                if (i_sts.mac_done) begin
                    n_state = ST_BLD_WR;
                end
            end
            ST_BLD_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = mat_addr(SEL_BASE, r_i, r_j);
                o_cmd.wr_src  = WR_ACC;
                n_i     = adv_i;
                n_j     = adv_j;
                n_state = cell_last ? ST_EVAL : ST_BLD_BAS;
            end
            ST_EVAL: begin
                if (r_e == '0) begin
                    o_cmd.acc_clr = 1'b1;
                    n_j     = '0;
                    n_state = ST_FIN_RD;
                end else if (r_e[0]) begin
                    n_sq    = 1'b0;
                    n_i     = '0;
                    n_j     = '0;
                    n_t     = '0;
                    n_state = ST_PRD_RD;
                end else begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                n_e = r_e >> 1;
                if ((r_e >> 1) != '0) begin
                    n_sq    = 1'b1;
                    n_i     = '0;
                    n_j     = '0;
                    n_t     = '0;
                    n_state = ST_PRD_RD;
                end else begin
                    o_cmd.acc_clr = 1'b1;
                    n_j     = '0;
                    n_state = ST_FIN_RD;
                end
            end
            ST_PRD_RD: begin
                o_cmd.rd_a_addr = mat_addr(tgt, r_i, r_t);
                o_cmd.rd_b_addr = mat_addr(SEL_BASE, r_t, r_j);
                o_cmd.acc_clr   = (r_t == '0);
                n_state         = ST_PRD_LAT;
            end
            ST_PRD_LAT: begin
                o_cmd.mac_start = 1'b1;
                n_state         = ST_PRD_MAC;
            end
            ST_PRD_MAC: begin
                if (i_sts.mac_done) begin
                    if (r_t == kmax) begin
                        n_t     = '0;
                        n_state = ST_PRD_WR;
                    end else begin
                        n_t     = r_t + IDX_W'(1);
                        n_state = ST_PRD_RD;
                    end
                end
            end
            ST_PRD_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = mat_addr(SEL_SCRATCH, r_i, r_j);
                o_cmd.wr_src  = WR_ACC;
                n_i     = adv_i;
                n_j     = adv_j;
                n_state = cell_last ? ST_CPY_RD : ST_PRD_RD;
            end
            ST_CPY_RD: begin
                o_cmd.rd_a_addr = mat_addr(SEL_SCRATCH, r_i, r_j);
                n_state         = ST_CPY_WR;
            end
            ST_CPY_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = mat_addr(tgt, r_i, r_j);
                o_cmd.wr_src  = WR_RD_A;
                n_i = adv_i;
                n_j = adv_j;
                if (cell_last) begin
                    n_state = r_sq ? ST_EVAL : ST_SHIFT;
                end else begin
                    n_state = ST_CPY_RD;
                end
            end
            ST_FIN_RD: begin
                o_cmd.rd_b_addr = mat_addr(SEL_ACCUM, '0, r_j);
                n_state         = ST_FIN_LAT;
            end
            ST_FIN_LAT: begin
                o_cmd.mac_start = 1'b1;
                o_cmd.src_a     = SA_INIT;
                o_cmd.src_b     = SB_MEM;
                o_cmd.reg_idx   = kmax - r_j;
                n_state         = ST_FIN_MAC;
            end
            ST_FIN_MAC: begin
                if (i_sts.mac_done) begin
                    if (r_j == kmax) begin
                        n_state = ST_RESP;
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = ST_FIN_RD;
                    end
                end
            end
            ST_RESP: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_err   <= 1'b0;
            r_sq    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
            r_sq    <= n_sq;
        end
        r_i <= n_i;
        r_j <= n_j;
        r_t <= n_t;
        r_e <= n_e;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_RESP);
    assign o_err       = r_err;

endmodule

>>> hw/rtl/linear_recurrence_mod_matrix_power_unit.sv
// ----------------------------------------------------------------------------
// linear_recurrence_mod_matrix_power_unit
// Term n of an order-k linear recurrence mod p by companion matrix powers.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  in        i_in_valid / o_in_stall  i_in   (kind, slot, value, term_number)
//  out       o_out_valid/ i_out_stall o_out  (term_value, error)
//  cfg       i_cfg_valid/ o_cfg_ready i_cfg_index, i_cfg_data
//
//  A load is accepted without a stall; a query with n <= k uses one multiply.
//  A query with n > k runs P matrix products of k*k cells, each a k-term dot
//  product, P the number of matrix products (up to about 128); the single
//  bit-serial modular multiplier, one bit per cycle, sets its duration.
//  Reset is synchronous, active low; order and modulus reset to 1.
//  One request at a time: input stalls from accept until the result is taken.
// ----------------------------------------------------------------------------
module linear_recurrence_mod_matrix_power_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lrmp_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lrmp_pkg::t_out_item               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lrmp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lrmp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lrmp_pkg::*;

    logic [ORDER_W-1:0]    r_order;
    logic [VALUE_BITS-1:0] r_modulus;
    t_cmd                  cmd;
    t_sts                  sts;
    logic [VALUE_BITS-1:0] acc;
    logic                  err;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order   <= ORDER_W'(1);
            r_modulus <= VALUE_BITS'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ORDER:   r_order   <= i_cfg_data[ORDER_W-1:0];
                REG_MODULUS: r_modulus <= i_cfg_data[VALUE_BITS-1:0];
                default: ;
            endcase
        end
    end

    lrmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_order     (r_order),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_err       (err)
    );

    lrmp_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_in      (i_in),
        .i_modulus (r_modulus),
        .o_sts     (sts),
        .o_acc     (acc)
    );

    assign o_out.term_value = acc;
    assign o_out.error      = err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.error) |-> (o_out.term_value == '0))
        else $error("error result carries a nonzero value");

endmodule
